@@ rtl/core/tlts_pkg.sv @@
// Shared types and constants for the tank level, temperature and TDS supervisor.
// Holds request, response, configuration and state structs plus phase and level codes.
// No dependencies.
package tlts_pkg;

   localparam int TEMP_W = 8;
   localparam int TDS_W = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_LOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TDS_HIGH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TDS_LOW = 2'd3;

   localparam logic [TEMP_W-1:0] TEMP_HIGH_RESET = 8'd35;
   localparam logic [TEMP_W-1:0] TEMP_LOW_RESET = 8'd15;
   localparam logic [TDS_W-1:0] TDS_HIGH_RESET = 12'd90;
   localparam logic [TDS_W-1:0] TDS_LOW_RESET = 12'd30;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_DRAIN = 2'd1,
      PHASE_FILL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      LEVEL_UNDER = 2'd0,
      LEVEL_NORMAL = 2'd1,
      LEVEL_OVER = 2'd2
   } level_type;

   typedef struct packed {
      logic              high_probe_wet;
      logic              low_probe_wet;
      logic [TEMP_W-1:0] temperature;
      logic [TDS_W-1:0]  tds_ppm;
      logic              feeding;
   } req_type;

   typedef struct packed {
      logic       drain_on;
      logic       fill_on;
      logic       heat_on;
      logic       cool_on;
      logic       aerate_on;
      logic       buzzer_on;
      logic       lamp_on;
      logic [1:0] level_status;
      logic [1:0] exchange_phase;
      logic       alarm_active;
   } rsp_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_high_limit;
      logic [TEMP_W-1:0] temp_low_limit;
      logic [TDS_W-1:0]  tds_high_limit;
      logic [TDS_W-1:0]  tds_low_limit;
   } cfg_type;

   typedef struct packed {
      phase_type step;
      logic      lock;
      level_type level;
      logic      lamp;
   } state_type;

endpackage

@@ rtl/core/tlts_step.sv @@
// Per-tick supervision logic: level, temperature, TDS exchange and alarm decisions.
// Purely combinational; maps current state and one request to next state and response.
// Depends on tlts_pkg.
module tlts_step (
   input  tlts_pkg::cfg_type   cfg,
   input  tlts_pkg::state_type cur,
   input  tlts_pkg::req_type   req,
   output tlts_pkg::state_type nxt,
   output tlts_pkg::rsp_type   rsp
);

   logic                hot;
   logic                cold;
   logic                tds_valid;
   logic                tds_below_high;
   logic                trigger;
   logic                lock_mid;
   logic                drain;
   logic                fill;
   logic                alarm;
   tlts_pkg::phase_type step_mid;
   tlts_pkg::phase_type step_out;
   tlts_pkg::level_type level_out;
   logic                lock_out;
   logic                lamp_out;

   always_comb begin
      hot = (req.temperature != '0) && (req.temperature >= cfg.temp_high_limit);
      cold = (req.temperature != '0) && (req.temperature <= cfg.temp_low_limit);
      tds_valid = (req.tds_ppm != '0);
      tds_below_high = (req.tds_ppm < cfg.tds_high_limit);

      drain = 1'b0;
      fill = 1'b0;
      alarm = 1'b0;
      level_out = cur.level;

      if (cur.step == tlts_pkg::PHASE_IDLE) begin
         if (req.high_probe_wet) begin
            drain = 1'b1;
            alarm = 1'b1;
            level_out = tlts_pkg::LEVEL_OVER;
         end else if (!req.low_probe_wet) begin
            fill = 1'b1;
            alarm = 1'b1;
            level_out = tlts_pkg::LEVEL_UNDER;
         end else begin
            level_out = tlts_pkg::LEVEL_NORMAL;
         end
      end

      if (hot || cold) begin
         alarm = 1'b1;
      end

      lock_mid = cur.lock & ~tds_below_high;
      trigger = tds_valid && !tds_below_high && !lock_mid;
      step_mid = cur.step;
      if (trigger) begin
         if (cur.step == tlts_pkg::PHASE_IDLE) begin
            step_mid = tlts_pkg::PHASE_DRAIN;
         end
      end else if (tds_valid && (req.tds_ppm <= cfg.tds_low_limit)) begin
         alarm = 1'b1;
      end

      lock_out = lock_mid;
      case (step_mid)
         tlts_pkg::PHASE_DRAIN: begin
            drain = 1'b1;
            fill = 1'b0;
            alarm = 1'b1;
            step_out = req.low_probe_wet ? tlts_pkg::PHASE_DRAIN : tlts_pkg::PHASE_FILL;
         end
         tlts_pkg::PHASE_FILL: begin
            drain = 1'b0;
            fill = ~req.high_probe_wet;
            alarm = 1'b1;
            step_out = req.high_probe_wet ? tlts_pkg::PHASE_IDLE : tlts_pkg::PHASE_FILL;
            if (req.high_probe_wet) begin
               lock_out = 1'b1;
            end
         end
         default: begin
            step_out = tlts_pkg::PHASE_IDLE;
         end
      endcase

      lamp_out = alarm & ~cur.lamp;

      nxt.step = step_out;
      nxt.lock = lock_out;
      nxt.level = level_out;
      nxt.lamp = lamp_out;

      rsp.drain_on = drain;
      rsp.fill_on = fill;
      rsp.heat_on = cold & ~hot;
      rsp.cool_on = hot;
      rsp.aerate_on = ~req.feeding | hot;
      rsp.buzzer_on = alarm;
      rsp.lamp_on = lamp_out;
      rsp.level_status = level_out;
      rsp.exchange_phase = step_out;
      rsp.alarm_active = alarm;
   end

endmodule

@@ rtl/core/tank_level_temp_tds_supervisor.sv @@
// Top level of the tank level, temperature and TDS supervisor.
// Input register, tlts_step decision logic, response register and CSR bank.
// Depends on tlts_pkg and tlts_step.
//
// Usage:
//   Each request on req_ is one supervision tick (probes, temperature, TDS, feeding).
//   Each request yields exactly one response on rsp_ with the relay, buzzer and lamp
//   drives plus level status, exchange phase and alarm.
//   Four limit registers are written through csr_ (index 0 temp high, 1 temp low,
//   2 TDS high, 3 TDS low); csr_ready is always high. Write them only while idle.
//   Throughput: one request per cycle while rsp_ready is high; the input register and
//   the response register form a two-stage pipeline, and the tank state updates as a
//   request leaves the input register.
//   Stall: while rsp_ready is low the response holds; the input register still takes
//   one more request, then req_ready drops until the response is taken.
//   Reset: synchronous, active high; empties both stages, restores the default limits,
//   and sets phase idle, unlocked, level normal, lamp off.
module tank_level_temp_tds_supervisor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tlts_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tlts_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tlts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tlts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                in_valid_ff;
   logic                in_valid_in;
   tlts_pkg::req_type   in_data_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   tlts_pkg::rsp_type   out_data_ff;
   tlts_pkg::state_type state_ff;
   tlts_pkg::state_type state_in;
   tlts_pkg::cfg_type   cfg_ff;
   tlts_pkg::cfg_type   cfg_in;
   tlts_pkg::rsp_type   step_rsp;
   logic                advance;
   logic                req_take;

   tlts_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (in_data_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tlts_pkg::CSR_TEMP_HIGH: cfg_in.temp_high_limit = csr_wdata[tlts_pkg::TEMP_W-1:0];
            tlts_pkg::CSR_TEMP_LOW:  cfg_in.temp_low_limit = csr_wdata[tlts_pkg::TEMP_W-1:0];
            tlts_pkg::CSR_TDS_HIGH:  cfg_in.tds_high_limit = csr_wdata[tlts_pkg::TDS_W-1:0];
            tlts_pkg::CSR_TDS_LOW:   cfg_in.tds_low_limit = csr_wdata[tlts_pkg::TDS_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.step <= tlts_pkg::PHASE_IDLE;
         state_ff.lock <= 1'b0;
         state_ff.level <= tlts_pkg::LEVEL_NORMAL;
         state_ff.lamp <= 1'b0;
         cfg_ff.temp_high_limit <= tlts_pkg::TEMP_HIGH_RESET;
         cfg_ff.temp_low_limit <= tlts_pkg::TEMP_LOW_RESET;
         cfg_ff.tds_high_limit <= tlts_pkg::TDS_HIGH_RESET;
         cfg_ff.tds_low_limit <= tlts_pkg::TDS_LOW_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_pumps_need_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.alarm_active |->
         !rsp_data.drain_on && !rsp_data.fill_on && !rsp_data.lamp_on)
      else $error("pump or lamp active without alarm");

   a_lock_after_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.lock) |-> $past(state_ff.step) == tlts_pkg::PHASE_FILL
         && state_ff.step == tlts_pkg::PHASE_IDLE)
      else $error("lock set outside end of fill");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a request leaving the input register");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the tank level, temperature and TDS supervisor: queued ticks,
// clocked request driver and response monitor, in-bench tick predictor, limit writes.
// Depends on tlts_pkg and tank_level_temp_tds_supervisor.
module tb_top;

   localparam int QUIET_LIMIT = 500;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int PHASE_TICKS = 116;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tlts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tlts_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tlts_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tlts_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tlts_pkg::req_type tick_queue[$];
   tlts_pkg::rsp_type expected_rsp[$];

   tlts_pkg::cfg_type limits;
   tlts_pkg::phase_type cur_phase;
   tlts_pkg::level_type level_mem;
   logic relock;
   logic lamp_mem;
   int water = 1;
   bit idle_enable = 1'b1;

   int ticks_sent = 0;
   int rsp_seen = 0;
   int fail_count = 0;
   int mismatch_count = 0;
   int exchanges = 0;
   int settings_run = 1;
   int stall_left = 0;
   int quiet_cycles = 0;

   tank_level_temp_tds_supervisor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic tlts_pkg::rsp_type supervise_tick(input tlts_pkg::req_type t);
      tlts_pkg::rsp_type o;
      logic hot;
      logic cold;
      logic alarm;
      o = '0;
      alarm = 1'b0;
      hot = (t.temperature != 0) && (t.temperature >= limits.temp_high_limit);
      cold = (t.temperature != 0) && (t.temperature <= limits.temp_low_limit);
      if (cur_phase == tlts_pkg::PHASE_IDLE) begin
         if (t.high_probe_wet) begin
            o.drain_on = 1'b1;
            alarm = 1'b1;
            level_mem = tlts_pkg::LEVEL_OVER;
         end else if (!t.low_probe_wet) begin
            o.fill_on = 1'b1;
            alarm = 1'b1;
            level_mem = tlts_pkg::LEVEL_UNDER;
         end else begin
            level_mem = tlts_pkg::LEVEL_NORMAL;
         end
      end
      if (hot) begin
         o.cool_on = 1'b1;
         alarm = 1'b1;
      end else if (cold) begin
         o.heat_on = 1'b1;
         alarm = 1'b1;
      end
      if (t.tds_ppm < limits.tds_high_limit)
         relock = 1'b0;
      if (t.tds_ppm != 0 && t.tds_ppm >= limits.tds_high_limit && !relock) begin
         if (cur_phase == tlts_pkg::PHASE_IDLE) begin
            cur_phase = tlts_pkg::PHASE_DRAIN;
            o.fill_on = 1'b0;
            exchanges++;
         end
      end else if (t.tds_ppm != 0 && t.tds_ppm <= limits.tds_low_limit) begin
         alarm = 1'b1;
      end
      case (cur_phase)
         tlts_pkg::PHASE_DRAIN: begin
            o.drain_on = 1'b1;
            o.fill_on = 1'b0;
            alarm = 1'b1;
            if (!t.low_probe_wet)
               cur_phase = tlts_pkg::PHASE_FILL;
         end
         tlts_pkg::PHASE_FILL: begin
            o.drain_on = 1'b0;
            o.fill_on = 1'b1;
            alarm = 1'b1;
            if (t.high_probe_wet) begin
               o.fill_on = 1'b0;
               cur_phase = tlts_pkg::PHASE_IDLE;
               relock = 1'b1;
            end
         end
         default: cur_phase = tlts_pkg::PHASE_IDLE;
      endcase
      o.aerate_on = !t.feeding || hot;
      lamp_mem = alarm ? !lamp_mem : 1'b0;
      o.buzzer_on = alarm;
      o.lamp_on = lamp_mem;
      o.level_status = level_mem;
      o.exchange_phase = cur_phase;
      o.alarm_active = alarm;
      return o;
   endfunction

   function automatic tlts_pkg::req_type random_tick();
      tlts_pkg::req_type t;
      int pick;
      int v;
      if ($urandom_range(99) < 85) begin
         water = water + $urandom_range(2) - 1;
         if (water < 0) water = 0;
         if (water > 2) water = 2;
         t.high_probe_wet = (water == 2);
         t.low_probe_wet = (water >= 1);
      end else begin
         t.high_probe_wet = 1'($urandom_range(1));
         t.low_probe_wet = 1'($urandom_range(1));
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
         t.temperature = '0;
      end else if (pick < 55) begin
         v = ($urandom_range(1) ? limits.temp_high_limit : limits.temp_low_limit)
             + $urandom_range(4) - 2;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         t.temperature = 8'(v);
      end else begin
         t.temperature = 8'($urandom_range(255, 1));
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
         v = limits.tds_high_limit + $urandom_range(6) - 3;
      end else if (pick < 55) begin
         v = (limits.tds_high_limit == 0) ? 0 : $urandom_range(limits.tds_high_limit - 1);
      end else if (pick < 65) begin
         v = 0;
      end else if (pick < 75) begin
         v = limits.tds_low_limit + $urandom_range(4) - 2;
      end else begin
         v = $urandom_range(4095);
      end
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      t.tds_ppm = 12'(v);
      t.feeding = 1'($urandom_range(1));
      return t;
   endfunction

   function automatic string differing_fields(input tlts_pkg::rsp_type want,
                                              input tlts_pkg::rsp_type got);
      string s;
      s = "";
      if (got.drain_on !== want.drain_on) s = {s, " drain_on"};
      if (got.fill_on !== want.fill_on) s = {s, " fill_on"};
      if (got.heat_on !== want.heat_on) s = {s, " heat_on"};
      if (got.cool_on !== want.cool_on) s = {s, " cool_on"};
      if (got.aerate_on !== want.aerate_on) s = {s, " aerate_on"};
      if (got.buzzer_on !== want.buzzer_on) s = {s, " buzzer_on"};
      if (got.lamp_on !== want.lamp_on) s = {s, " lamp_on"};
      if (got.level_status !== want.level_status) s = {s, " level_status"};
      if (got.exchange_phase !== want.exchange_phase) s = {s, " exchange_phase"};
      if (got.alarm_active !== want.alarm_active) s = {s, " alarm_active"};
      return s;
   endfunction

   task automatic add_tick(input int hi, input int lo, input int temp, input int tds,
                           input int feed);
      tlts_pkg::req_type t;
      t.high_probe_wet = 1'(hi);
      t.low_probe_wet = 1'(lo);
      t.temperature = 8'(temp);
      t.tds_ppm = 12'(tds);
      t.feeding = 1'(feed);
      tick_queue.push_back(t);
   endtask

   task automatic write_limit(input logic [tlts_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [tlts_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tlts_pkg::CSR_TEMP_HIGH: limits.temp_high_limit = value[tlts_pkg::TEMP_W-1:0];
         tlts_pkg::CSR_TEMP_LOW: limits.temp_low_limit = value[tlts_pkg::TEMP_W-1:0];
         tlts_pkg::CSR_TDS_HIGH: limits.tds_high_limit = value;
         tlts_pkg::CSR_TDS_LOW: limits.tds_low_limit = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (tick_queue.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            expected_rsp.push_back(supervise_tick(req_data));
            ticks_sent++;
         end
         if (tick_queue.size() != 0 && !(idle_enable && $urandom_range(99) < 18)) begin
            req_data <= tick_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response %p", rsp_data);
            end else begin
               tlts_pkg::rsp_type want;
               want = expected_rsp.pop_front();
               if (differing_fields(want, rsp_data) != "") begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response %0d mismatch in%s: expected %p, got %p", rsp_seen,
                              differing_fields(want, rsp_data), want, rsp_data);
               end
            end
            if (rsp_seen % 200 == 100)
               stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_enable && $urandom_range(99) < 18);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      limits.temp_high_limit = tlts_pkg::TEMP_HIGH_RESET;
      limits.temp_low_limit = tlts_pkg::TEMP_LOW_RESET;
      limits.tds_high_limit = tlts_pkg::TDS_HIGH_RESET;
      limits.tds_low_limit = tlts_pkg::TDS_LOW_RESET;
      cur_phase = tlts_pkg::PHASE_IDLE;
      level_mem = tlts_pkg::LEVEL_NORMAL;
      relock = 1'b0;
      lamp_mem = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_tick(0, 1, 0, 0, 0);
      add_tick(1, 1, 255, 4095, 1);
      add_tick(1, 0, 35, 50, 1);
      add_tick(0, 0, 15, 50, 0);
      add_tick(1, 1, 20, 95, 0);
      add_tick(0, 1, 20, 95, 0);
      add_tick(0, 1, 20, 0, 0);
      add_tick(0, 0, 20, 90, 1);
      add_tick(1, 1, 20, 30, 0);
      add_tick(0, 1, 20, 31, 0);
      add_tick(0, 1, 20, 1, 0);
      add_tick(0, 1, 20, 1, 0);
      add_tick(0, 1, 36, 60, 1);
      add_tick(0, 1, 14, 60, 1);
      add_tick(0, 1, 1, 4094, 0);
      add_tick(0, 1, 16, 4095, 0);
      add_tick(0, 0, 16, 4095, 0);
      add_tick(0, 0, 16, 4095, 0);
      add_tick(1, 0, 16, 4095, 0);
      add_tick(1, 0, 16, 4095, 0);
      add_tick(0, 0, 254, 89, 1);
      add_tick(1, 1, 0, 0, 1);
      add_tick(0, 1, 8'hAA, 12'h555, 0);
      add_tick(0, 1, 8'h55, 12'hAAA, 1);

      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         case (ph)
            1: begin
               write_limit(tlts_pkg::CSR_TEMP_HIGH, 12'hF00);
               write_limit(tlts_pkg::CSR_TEMP_LOW, 12'h0FF);
               write_limit(tlts_pkg::CSR_TDS_HIGH, 12'd0);
               write_limit(tlts_pkg::CSR_TDS_LOW, 12'hFFF);
            end
            2: begin
               write_limit(tlts_pkg::CSR_TEMP_HIGH, 12'h0FF);
               write_limit(tlts_pkg::CSR_TEMP_LOW, 12'h000);
               write_limit(tlts_pkg::CSR_TDS_HIGH, 12'hFFF);
               write_limit(tlts_pkg::CSR_TDS_LOW, 12'h000);
            end
            4: begin
               write_limit(tlts_pkg::CSR_TEMP_HIGH, 12'(tlts_pkg::TEMP_HIGH_RESET));
               write_limit(tlts_pkg::CSR_TEMP_LOW, 12'(tlts_pkg::TEMP_LOW_RESET));
               write_limit(tlts_pkg::CSR_TDS_HIGH, tlts_pkg::TDS_HIGH_RESET);
               write_limit(tlts_pkg::CSR_TDS_LOW, tlts_pkg::TDS_LOW_RESET);
            end
            default: begin
               write_limit(tlts_pkg::CSR_TEMP_HIGH,
                           12'($urandom_range(60, 20) | ($urandom_range(15) << 8)));
               write_limit(tlts_pkg::CSR_TEMP_LOW, 12'($urandom_range(25, 5)));
               write_limit(tlts_pkg::CSR_TDS_HIGH, 12'($urandom_range(400, 50)));
               write_limit(tlts_pkg::CSR_TDS_LOW, 12'($urandom_range(60, 10)));
            end
         endcase
         settings_run++;
         idle_enable = (ph != 2);
         for (int i = 0; i < PHASE_TICKS; i++)
            tick_queue.push_back(random_tick());
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d ticks over %0d limit settings, %0d responses checked, %0d mismatches",
               ticks_sent, settings_run, rsp_seen, mismatch_count);
      $display("%0d water exchanges started, receiver hold-offs of %0d cycles included",
               exchanges, HOLD_OFF_CYCLES);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/tlts_pkg.sv
rtl/core/tlts_step.sv
rtl/core/tank_level_temp_tds_supervisor.sv
bench/tb_top.sv
